// ----- rtl/fcs_pkg.sv -----
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types, constants and codes of the frustum cell select block.
// ----------------------------------------------------------------------------
package fcs_pkg;

   // defaults for the top level parameters
   localparam int COORD_BITS_DEF      = 20;
   localparam int CELL_INDEX_BITS_DEF = 24;

   // fixed field widths
   localparam int AXIS_BITS   = 20;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int DIST_SHIFT  = 10;   // Q16.16 to Q.26 scaling

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // lateral test datapath: operands, partial products, accumulator, result
   localparam int OPW    = 48;
   localparam int HALF_W = 24;
   localparam int ACC_W  = 96;
   localparam int RES_W  = 97;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORIGIN,
      CSR_FORWARD,
      CSR_RIGHT,
      CSR_UP,
      CSR_NEAR,
      CSR_FAR,
      CSR_NEAR_EXT,
      CSR_FAR_EXT
   } csr_index_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [3*AXIS_BITS-1:0] forward_axis;
      logic [3*AXIS_BITS-1:0] right_axis;
      logic [3*AXIS_BITS-1:0] up_axis;
      logic [31:0]            near_dist;
      logic [31:0]            far_dist;
      logic [63:0]            near_ext;
      logic [63:0]            far_ext;
   } fcs_cfg_type;

   // queue head control towards the back end
   typedef struct packed {
      logic valid;
      logic has_point;
      logic last;
   } fcs_ent_ctrl_type;

   // back end sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROJ,
      ST_RANGE,
      ST_LOAD,
      ST_MUL,
      ST_SIGN,
      ST_CMP,
      ST_CLOSE
   } fcs_state_type;

endpackage

// ----- rtl/fcs_front.sv -----
// ----------------------------------------------------------------------------
// fcs_front
// Takes request transfers, forms the offset from the apex, drops bubbles and
// queues points and cell closes for the back end.
// ----------------------------------------------------------------------------
module fcs_front import fcs_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_point_x,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   input  logic signed [COORD_BITS-1:0]  req_point_z,
   input  logic                          req_no_point,
   input  logic                          req_last_of_cell,
   input  logic [3*COORD_BITS-1:0]       origin,
   input  logic                          pop,
   output fcs_ent_ctrl_type              ent_ctrl,
   output logic [3*(COORD_BITS+1)-1:0]   ent_v
);

   localparam int VW    = COORD_BITS + 1;
   localparam int EW    = 3*VW + 2;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [EW-1:0]    q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic signed [COORD_BITS-1:0] org_x, org_y, org_z;
   logic signed [VW-1:0]         vx, vy, vz;
   logic                         accept, push;
   logic [EW-1:0]                entry;

   // offset from the apex
   assign org_x = origin[0*COORD_BITS +: COORD_BITS];
   assign org_y = origin[1*COORD_BITS +: COORD_BITS];
   assign org_z = origin[2*COORD_BITS +: COORD_BITS];
   assign vx    = VW'(req_point_x) - VW'(org_x);
   assign vy    = VW'(req_point_y) - VW'(org_y);
   assign vz    = VW'(req_point_z) - VW'(org_z);

   // classify: a bubble (no point, no close) is taken and dropped
   assign req_stall = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (!req_no_point || req_last_of_cell);
   assign entry     = {!req_no_point, req_last_of_cell, vz, vy, vx};

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   // queue head
   assign ent_ctrl.valid     = (cnt_ff != '0);
   assign ent_ctrl.has_point = q_ff[rd_ptr_ff][EW-1];
   assign ent_ctrl.last      = q_ff[rd_ptr_ff][EW-2];
   assign ent_v              = q_ff[rd_ptr_ff][3*VW-1:0];

endmodule

// ----- rtl/fcs_back.sv -----
// ----------------------------------------------------------------------------
// fcs_back
// Sequencer that projects each queued point, runs the depth test and the
// lateral tests, the latter on a shared multiplier, ANDs the result over the
// cell and emits the cell index on close.
// ----------------------------------------------------------------------------
module fcs_back import fcs_pkg::*; #(
   parameter int COORD_BITS      = COORD_BITS_DEF,
   parameter int CELL_INDEX_BITS = CELL_INDEX_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fcs_cfg_type                  cfg,
   input  fcs_ent_ctrl_type             ent_ctrl,
   input  logic [3*(COORD_BITS+1)-1:0]  ent_v,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [CELL_INDEX_BITS-1:0]   rsp_cell_index
);

   localparam int VW     = COORD_BITS + 1;
   localparam int PROJ_W = VW + AXIS_BITS + 2;
   localparam int PAD_W  = OPW - 32 - DIST_SHIFT;

   function automatic logic signed [OPW-1:0] abs_op(input logic signed [OPW-1:0] x);
      abs_op = x[OPW-1] ? -x : x;
   endfunction

   fcs_state_type state_ff, state_in;

   logic signed [VW-1:0]     v_ff [3];
   logic signed [VW-1:0]     v_in [3];
   logic                     last_ff, last_in;
   logic [1:0]               axis_ff, axis_in;
   logic [1:0]               comp_ff, comp_in;
   logic signed [PROJ_W-1:0] proj_ff [3];
   logic signed [PROJ_W-1:0] proj_in [3];
   logic                     lat_ff, lat_in;
   logic                     sel_ff, sel_in;
   logic [1:0]               pp_ff, pp_in;
   logic [OPW-1:0]           opa_ff, opa_in, opb_ff, opb_in;
   logic                     neg_ff, neg_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic signed [RES_W-1:0]  lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic signed [OPW-1:0]    e_ff, e_in, a_ff, a_in;
   logic signed [OPW-1:0]    diff_ff [2];
   logic signed [OPW-1:0]    diff_in [2];
   logic                     all_inside_ff, all_inside_in;
   logic [CELL_INDEX_BITS-1:0] cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CELL_INDEX_BITS-1:0] rsp_idx_ff, rsp_idx_in;

   logic [3*AXIS_BITS-1:0]          ax_vec;
   logic signed [AXIS_BITS-1:0]     ax_sel;
   logic signed [VW+AXIS_BITS-1:0]  mp;
   logic signed [OPW-1:0] d_w, nd_w, fd_w, new_w, neh_w, few_w, feh_w;
   logic signed [OPW-1:0] mag_r, mag_u, df_r, df_u, op_x, op_y;
   logic                  in_range, span_zero, span_pos, ext_ok, out_free;
   logic [2*HALF_W-1:0]   part;
   logic [ACC_W-1:0]      part_sh;
   logic [1:0]            sh;
   logic signed [RES_W-1:0] res;

   // projection multiplier: one component per cycle
   always_comb begin
      case (axis_ff)
         2'd0:    ax_vec = cfg.forward_axis;
         2'd1:    ax_vec = cfg.right_axis;
         default: ax_vec = cfg.up_axis;
      endcase
   end
   assign ax_sel = ax_vec[comp_ff*AXIS_BITS +: AXIS_BITS];
   assign mp     = v_ff[comp_ff] * ax_sel;

   // distances and extents scaled to Q.26
   assign d_w   = OPW'(proj_ff[0]);
   assign nd_w  = $signed({{PAD_W{cfg.near_dist[31]}}, cfg.near_dist, {DIST_SHIFT{1'b0}}});
   assign fd_w  = $signed({{PAD_W{cfg.far_dist[31]}}, cfg.far_dist, {DIST_SHIFT{1'b0}}});
   assign new_w = $signed({{PAD_W{1'b0}}, cfg.near_ext[63:32], {DIST_SHIFT{1'b0}}});
   assign neh_w = $signed({{PAD_W{1'b0}}, cfg.near_ext[31:0], {DIST_SHIFT{1'b0}}});
   assign few_w = $signed({{PAD_W{1'b0}}, cfg.far_ext[63:32], {DIST_SHIFT{1'b0}}});
   assign feh_w = $signed({{PAD_W{1'b0}}, cfg.far_ext[31:0], {DIST_SHIFT{1'b0}}});
   assign mag_r = abs_op(OPW'(proj_ff[1]));
   assign mag_u = abs_op(OPW'(proj_ff[2]));
   assign df_r  = few_w - new_w;
   assign df_u  = feh_w - neh_w;

   // depth test without min/max: d lies between the two faces
   assign in_range  = (d_w >= nd_w && d_w <= fd_w) || (d_w >= fd_w && d_w <= nd_w);
   assign span_zero = (cfg.near_dist == cfg.far_dist);
   assign span_pos  = (fd_w > nd_w);
   assign ext_ok    = (cfg.near_ext[63:32] != '0) && (cfg.near_ext[31:0] != '0)
                   && (cfg.far_ext[63:32] != '0) && (cfg.far_ext[31:0] != '0);

   // lateral operands: (|c| - E_near) * |span| against e * (E_far - E_near)
   assign op_x = sel_ff ? e_ff : diff_ff[lat_ff];
   assign op_y = sel_ff ? (lat_ff ? df_u : df_r) : a_ff;

   // partial products of magnitude halves
   assign part = opa_ff[pp_ff[0]*HALF_W +: HALF_W] * opb_ff[pp_ff[1]*HALF_W +: HALF_W];
   assign sh   = {pp_ff[0] & pp_ff[1], pp_ff[0] ^ pp_ff[1]};
   always_comb begin
      case (sh)
         2'd0:    part_sh = ACC_W'(part);
         2'd1:    part_sh = ACC_W'(part) << HALF_W;
         default: part_sh = ACC_W'(part) << (2*HALF_W);
      endcase
   end
   assign res = neg_ff ? (RES_W'(0) - $signed({1'b0, acc_ff})) : $signed({1'b0, acc_ff});

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == ST_IDLE) && ent_ctrl.valid;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      v_in          = v_ff;
      last_in       = last_ff;
      axis_in       = axis_ff;
      comp_in       = comp_ff;
      proj_in       = proj_ff;
      lat_in        = lat_ff;
      sel_in        = sel_ff;
      pp_in         = pp_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      lhs_in        = lhs_ff;
      rhs_in        = rhs_ff;
      e_in          = e_ff;
      a_in          = a_ff;
      diff_in       = diff_ff;
      all_inside_in = all_inside_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_idx_in    = rsp_idx_ff;

      // result transfer frees the output register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (ent_ctrl.valid) begin
               v_in[0] = ent_v[0*VW +: VW];
               v_in[1] = ent_v[1*VW +: VW];
               v_in[2] = ent_v[2*VW +: VW];
               last_in = ent_ctrl.last;
               if (ent_ctrl.has_point) begin
                  proj_in[0] = '0;
                  proj_in[1] = '0;
                  proj_in[2] = '0;
                  axis_in    = 2'd0;
                  comp_in    = 2'd0;
                  state_in   = ST_PROJ;
               end else if (ent_ctrl.last) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_PROJ: begin
            proj_in[axis_ff] = proj_ff[axis_ff] + PROJ_W'(mp);
            if (comp_ff == 2'd2) begin
               comp_in = 2'd0;
               axis_in = axis_ff + 1'b1;
               if (axis_ff == 2'd2) begin
                  state_in = ST_RANGE;
               end
            end else begin
               comp_in = comp_ff + 1'b1;
            end
         end
         ST_RANGE: begin
            if (!in_range) begin
               all_inside_in = 1'b0;
               state_in      = last_ff ? ST_CLOSE : ST_IDLE;
            end else if (span_zero) begin
               // equal distances: near extents unchanged
               if (mag_r > new_w || mag_u > neh_w) begin
                  all_inside_in = 1'b0;
               end
               state_in = last_ff ? ST_CLOSE : ST_IDLE;
            end else begin
               e_in       = span_pos ? d_w - nd_w : nd_w - d_w;
               a_in       = span_pos ? fd_w - nd_w : nd_w - fd_w;
               diff_in[0] = mag_r - new_w;
               diff_in[1] = mag_u - neh_w;
               lat_in     = 1'b0;
               sel_in     = 1'b0;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            opa_in   = abs_op(op_x);
            opb_in   = abs_op(op_y);
            neg_in   = op_x[OPW-1] ^ op_y[OPW-1];
            acc_in   = '0;
            pp_in    = 2'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            acc_in = acc_ff + part_sh;
            pp_in  = pp_ff + 1'b1;
            if (pp_ff == 2'd3) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (!sel_ff) begin
               lhs_in   = res;
               sel_in   = 1'b1;
               state_in = ST_LOAD;
            end else begin
               rhs_in   = res;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (lhs_ff > rhs_ff) begin
               all_inside_in = 1'b0;
               state_in      = last_ff ? ST_CLOSE : ST_IDLE;
            end else if (!lat_ff) begin
               lat_in   = 1'b1;
               sel_in   = 1'b0;
               state_in = ST_LOAD;
            end else begin
               state_in = last_ff ? ST_CLOSE : ST_IDLE;
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               if (all_inside_ff && ext_ok) begin
                  rsp_valid_in = 1'b1;
                  rsp_idx_in   = cnt_ff;
               end
               if (cnt_ff != '1) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               all_inside_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         all_inside_ff <= 1'b1;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         all_inside_ff <= all_inside_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      v_ff       <= v_in;
      last_ff    <= last_in;
      axis_ff    <= axis_in;
      comp_ff    <= comp_in;
      proj_ff    <= proj_in;
      lat_ff     <= lat_in;
      sel_ff     <= sel_in;
      pp_ff      <= pp_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      neg_ff     <= neg_in;
      acc_ff     <= acc_in;
      lhs_ff     <= lhs_in;
      rhs_ff     <= rhs_in;
      e_ff       <= e_in;
      a_ff       <= a_in;
      diff_ff    <= diff_in;
      rsp_idx_ff <= rsp_idx_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_index = rsp_idx_ff;

endmodule

// ----- rtl/frustum_cell_select_core.sv -----
// ----------------------------------------------------------------------------
// frustum_cell_select_core
// View frustum cell selector: register file, front end and back end.
// ----------------------------------------------------------------------------
// Points arrive one per request transfer and go through a two-entry queue to
// a sequencer that works on one point at a time. Each point is dequeued, runs
// 9 projection multiply-accumulates and a range step for the depth test and,
// when that passes, the width and height lateral tests, whose four wide
// products run as 24x24 partial products on one shared multiplier; a cell
// close adds a close step. The request side keeps accepting until the queue
// holds two entries, and a result waits in its own output register without
// holding back the next point, though the next cell close waits for it.
module frustum_cell_select_core import fcs_pkg::*; #(
   parameter int COORD_BITS      = COORD_BITS_DEF,
   parameter int CELL_INDEX_BITS = CELL_INDEX_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_point_x,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   input  logic signed [COORD_BITS-1:0]  req_point_z,
   input  logic                          req_no_point,
   input  logic                          req_last_of_cell,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CELL_INDEX_BITS-1:0]    rsp_cell_index,
   input  logic                          csr_wen,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   logic [3*COORD_BITS-1:0] origin_ff;
   fcs_cfg_type             cfg_ff;
   fcs_ent_ctrl_type        ent_ctrl;
   logic [3*(COORD_BITS+1)-1:0] ent_v;
   logic                    pop;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         cfg_ff    <= '0;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_ORIGIN:   origin_ff           <= csr_wdata[3*COORD_BITS-1:0];
            CSR_FORWARD:  cfg_ff.forward_axis <= csr_wdata[3*AXIS_BITS-1:0];
            CSR_RIGHT:    cfg_ff.right_axis   <= csr_wdata[3*AXIS_BITS-1:0];
            CSR_UP:       cfg_ff.up_axis      <= csr_wdata[3*AXIS_BITS-1:0];
            CSR_NEAR:     cfg_ff.near_dist    <= csr_wdata[31:0];
            CSR_FAR:      cfg_ff.far_dist     <= csr_wdata[31:0];
            CSR_NEAR_EXT: cfg_ff.near_ext     <= csr_wdata;
            CSR_FAR_EXT:  cfg_ff.far_ext      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   fcs_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .req_no_point     (req_no_point),
      .req_last_of_cell (req_last_of_cell),
      .origin           (origin_ff),
      .pop              (pop),
      .ent_ctrl         (ent_ctrl),
      .ent_v            (ent_v)
   );

   fcs_back #(
      .COORD_BITS      (COORD_BITS),
      .CELL_INDEX_BITS (CELL_INDEX_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .ent_ctrl       (ent_ctrl),
      .ent_v          (ent_v),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_index (rsp_cell_index)
   );

endmodule

// ----- rtl/fcs_checker.sv -----
// ----------------------------------------------------------------------------
// fcs_checker
// Port level checks of the frustum cell select core, bound to the top level.
// ----------------------------------------------------------------------------
module fcs_checker import fcs_pkg::*; #(
   parameter int CELL_INDEX_BITS = CELL_INDEX_BITS_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [CELL_INDEX_BITS-1:0] rsp_cell_index
);

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_index))
      else $error("result changed while stalled");

   // a result only leaves by transfer or reset
   a_rsp_leave: assert property (@(posedge clock)
      $fell(rsp_valid) |-> $past(!rsp_stall) || $past(reset))
      else $error("result dropped without transfer");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // reset empties the queue, so requests are taken straight away
   a_req_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("request stalled after reset");

endmodule

bind frustum_cell_select_core fcs_checker #(
   .CELL_INDEX_BITS (CELL_INDEX_BITS)
) u_fcs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_cell_index (rsp_cell_index)
);

// ----- dv/frustum_cell_select_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cell_select_core_tb
// Self-checking bench for the frustum cell selector. A clocked driver offers
// points from a pending queue, a shadow predictor works out the selected cell
// indexes as each point transfer is accepted, and a clocked monitor checks
// every result transfer against the oldest expected index. Several frustum
// settings and idling patterns are run in turn.
// ----------------------------------------------------------------------------
module frustum_cell_select_core_tb;
   import fcs_pkg::*;

   localparam int CW = COORD_BITS_DEF;
   localparam int IW = CELL_INDEX_BITS_DEF;

   typedef struct {
      logic signed [CW-1:0] x, y, z;
      bit                   no_pt, last;
   } point_item_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [CW-1:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic                 req_no_point = 1'b0, req_last_of_cell = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [IW-1:0]        rsp_cell_index;
   logic                 csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   frustum_cell_select_core dut (.*);

   always #5 clock = ~clock;

   // shadow registers and cell state
   logic [59:0] sh_origin, sh_fwd, sh_right, sh_up;
   logic signed [31:0] sh_near, sh_far;
   logic [63:0] sh_near_ext, sh_far_ext;
   bit          cell_all_in;
   logic [IW-1:0] cell_count;

   point_item_type pending_pts[$];
   point_item_type cur_pt;
   logic [IW-1:0] selected_cells[$];
   int err_count = 0;
   int send_idle_pct = 0, stall_pct = 0, hold_cycles = 0;

   // generator shaping (Q12.8, relative to origin)
   int org_x, org_y, org_z, gen_lo, gen_hi, gen_lat;
   bit gen_full;

   function automatic logic signed [63:0] fld(logic [59:0] p, int i);
      logic signed [19:0] t;
      t = p[i*20 +: 20];
      return 64'(t);
   endfunction

   function automatic logic signed [63:0] project_on(logic signed [63:0] v[3],
                                                     logic [59:0] axis);
      logic signed [63:0] s;
      s = 0;
      for (int i = 0; i < 3; i++) s += v[i] * fld(axis, i);
      return s;
   endfunction

   // lateral bound, interpolation by exact cross multiplication
   function automatic bit lateral_fits(logic signed [63:0] c, logic signed [63:0] d,
                                       logic signed [63:0] nd, logic signed [63:0] span,
                                       logic [31:0] ne_raw, logic [31:0] fe_raw);
      logic signed [127:0] mag, a, e, ne, fe, lhs, rhs;
      mag = (c < 0) ? -c : c;
      ne  = $signed({96'd0, ne_raw}) <<< 10;
      fe  = $signed({96'd0, fe_raw}) <<< 10;
      if (span == 0) return mag <= ne;
      a   = (span < 0) ? -span : span;
      e   = (span > 0) ? d - nd : nd - d;
      lhs = mag * a;
      rhs = ne * a + e * (fe - ne);
      return lhs <= rhs;
   endfunction

   function automatic bit point_inside(point_item_type p);
      logic signed [63:0] v[3];
      logic signed [63:0] d, nd, fd, lo, hi, span;
      v[0] = 64'(p.x) - fld(sh_origin, 0);
      v[1] = 64'(p.y) - fld(sh_origin, 1);
      v[2] = 64'(p.z) - fld(sh_origin, 2);
      d  = project_on(v, sh_fwd);
      nd = 64'(sh_near) * 1024;
      fd = 64'(sh_far) * 1024;
      lo = (nd < fd) ? nd : fd;
      hi = (nd < fd) ? fd : nd;
      span = fd - nd;
      if (d < lo || d > hi) return 1'b0;
      return lateral_fits(project_on(v, sh_right), d, nd, span,
                          sh_near_ext[63:32], sh_far_ext[63:32]) &&
             lateral_fits(project_on(v, sh_up), d, nd, span,
                          sh_near_ext[31:0], sh_far_ext[31:0]);
   endfunction

   // accumulate one accepted point, queue the index when a cell closes inside
   function automatic void select_cell(point_item_type p);
      bit ext_ok;
      if (!p.no_pt && !point_inside(p)) cell_all_in = 0;
      if (!p.last) return;
      ext_ok = sh_near_ext[63:32] != 0 && sh_near_ext[31:0] != 0 &&
               sh_far_ext[63:32] != 0 && sh_far_ext[31:0] != 0;
      if (cell_all_in && ext_ok) selected_cells = {selected_cells, cell_count};
      if (cell_count != {IW{1'b1}}) cell_count++;
      cell_all_in = 1;
   endfunction

   // driver: request side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) select_cell(cur_pt);
         if (!req_valid || !req_stall) begin
            if (pending_pts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_pt = pending_pts.pop_front();
               req_point_x      <= cur_pt.x;
               req_point_y      <= cur_pt.y;
               req_point_z      <= cur_pt.z;
               req_no_point     <= cur_pt.no_pt;
               req_last_of_cell <= cur_pt.last;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: result side, with optional long hold-off
   always @(posedge clock) begin
      logic [IW-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (selected_cells.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("unexpected cell_index %0d", rsp_cell_index);
            end else begin
               want = selected_cells.pop_front();
               if (rsp_cell_index !== want) begin
                  err_count++;
                  if (err_count <= 10)
                     $display("cell_index mismatch: exp %0d got %0d", want, rsp_cell_index);
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [63:0] val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ORIGIN:   sh_origin   = val[59:0];
         CSR_FORWARD:  sh_fwd      = val[59:0];
         CSR_RIGHT:    sh_right    = val[59:0];
         CSR_UP:       sh_up       = val[59:0];
         CSR_NEAR:     sh_near     = val[31:0];
         CSR_FAR:      sh_far      = val[31:0];
         CSR_NEAR_EXT: sh_near_ext = val;
         CSR_FAR_EXT:  sh_far_ext  = val;
         default: ;
      endcase
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [59:0] pack3(int a, int b, int c);
      return {c[19:0], b[19:0], a[19:0]};
   endfunction

   // frustum set-up: axis-aligned frame, distances and extents in Q16.16
   task automatic set_frustum(int ox, int oy, int oz, int fwd_sign,
                              int nd, int fd, logic [63:0] ne, logic [63:0] fe);
      org_x = ox; org_y = oy; org_z = oz;
      write_reg(CSR_ORIGIN,   64'(pack3(ox, oy, oz)));
      write_reg(CSR_FORWARD,  64'(pack3(fwd_sign * (1 << 18), 0, 0)));
      write_reg(CSR_RIGHT,    64'(pack3(0, 1 << 18, 0)));
      write_reg(CSR_UP,       64'(pack3(0, 0, 1 << 18)));
      write_reg(CSR_NEAR,     64'(nd));
      write_reg(CSR_FAR,      64'(fd));
      write_reg(CSR_NEAR_EXT, ne);
      write_reg(CSR_FAR_EXT,  fe);
   endtask

   task automatic add_pt(int x, int y, int z, bit np, bit last);
      point_item_type p;
      p.x = x[CW-1:0]; p.y = y[CW-1:0]; p.z = z[CW-1:0]; p.no_pt = np; p.last = last;
      pending_pts = {pending_pts, p};
   endtask

   // one random point inside the shaped region, or anywhere
   task automatic add_shaped_pt(bit last);
      int rx, ry, rz;
      if (gen_full) begin
         add_pt($urandom, $urandom, $urandom, 0, last);
      end else begin
         rx = gen_lo + int'($urandom_range(gen_hi - gen_lo));
         ry = int'($urandom_range(2 * gen_lat)) - gen_lat;
         rz = int'($urandom_range(2 * gen_lat)) - gen_lat;
         add_pt(org_x + rx, org_y + ry, org_z + rz, 0, last);
      end
   endtask

   // random traffic: mostly well-formed cells, some noise, bubbles, empty cells
   task automatic add_random(int n_items);
      int r, npts;
      while (n_items > 0) begin
         r = $urandom_range(99);
         if (r < 10) begin
            add_pt($urandom, $urandom, $urandom, 1'($urandom_range(1)),
                   1'($urandom_range(1)));
            n_items--;
         end else if (r < 15) begin
            add_pt($urandom, $urandom, $urandom, 1, 0);
         end else if (r < 22) begin
            add_pt($urandom, $urandom, $urandom, 1, 1);
            n_items--;
         end else begin
            npts = $urandom_range(1, 3);
            for (int i = 0; i < npts; i++) add_shaped_pt(i == npts - 1);
            n_items -= npts;
         end
      end
   endtask

   task automatic drain();
      while (pending_pts.size() != 0 || req_valid || selected_cells.size() != 0)
         @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic set_idling(int snd, int rcv);
      @(negedge clock);
      send_idle_pct = snd;
      stall_pct     = rcv;
   endtask

   initial begin
      sh_origin = '0; sh_fwd = '0; sh_right = '0; sh_up = '0;
      sh_near = '0; sh_far = '0; sh_near_ext = '0; sh_far_ext = '0;
      cell_all_in = 1; cell_count = '0;
      gen_full = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero extents, counter moves but nothing is selected
      @(negedge clock);
      add_pt(100, -100, 5, 0, 1);
      add_pt(0, 0, 0, 1, 1);
      add_pt(524287, -524288, 1, 0, 0);
      add_pt(-1, 2, 3, 0, 1);
      drain();

      // depth 1..100 along +x, widening frustum
      set_frustum(-25600, 300, -700, 1, 32'h0001_0000, 32'h0064_0000,
                  {32'h0001_0000, 32'h0002_0000}, {32'h0032_0000, 32'h0028_0000});
      gen_lo = 256; gen_hi = 25600; gen_lat = 6000;
      @(negedge clock);
      add_pt(-25600 + 256, 300, -700, 0, 1);            // on the near face axis
      add_pt(-25600 + 25600, 300 + 12800, -700, 0, 1);  // far corner of width
      add_pt(-25600 + 25600, 300, -700 - 10240, 0, 1);  // far corner of height
      add_pt(-25600 + 25600, 300 + 12801, -700, 0, 1);  // just outside width
      add_pt(-25600 + 255, 300, -700, 0, 1);            // just in front of near
      add_pt(-25600 + 25601, 300, -700, 0, 1);          // just past far
      add_pt(0, 0, 0, 1, 0);                            // bubble
      add_pt(0, 0, 0, 1, 1);                            // empty cell
      add_pt(-25600 + 5000, 300, -700, 0, 0);
      add_pt(524287, 524287, 524287, 0, 0);
      add_pt(-524288, -524288, -524288, 0, 1);
      add_pt(-25600 + 5000, 300 + 100, -700 - 100, 0, 0);
      add_pt(-25600 + 9000, 300, -700, 0, 1);
      add_random(40);
      drain();

      // near beyond far, sender idling
      set_frustum(1000, -2000, 3000, 1, 32'h003C_0000, 32'h0005_0000,
                  {32'h0020_0000, 32'h0010_0000}, {32'h0002_0000, 32'h0001_8000});
      gen_lo = 1280; gen_hi = 15360; gen_lat = 4000;
      set_idling(71, 0);
      add_random(80);
      drain();

      // equal distances, receiver stalling, then one long hold-off
      set_frustum(-300, 40000, 0, -1, 32'h001E_0000, 32'h001E_0000,
                  {32'h0004_0000, 32'h0003_0000}, {32'h0080_0000, 32'h0080_0000});
      gen_lo = -7680; gen_hi = -7680; gen_lat = 1100;
      set_idling(0, 71);
      add_random(60);
      drain();
      set_idling(0, 0);
      hold_cycles = 600;
      add_random(30);
      drain();

      // full-range registers, both sides idling
      write_reg(CSR_ORIGIN,   64'(60'hF_FFFF_80000_7FFFF));
      write_reg(CSR_FORWARD,  {$urandom, $urandom});
      write_reg(CSR_RIGHT,    64'(60'h8_0000_7FFFF_80000));
      write_reg(CSR_UP,       {$urandom, $urandom});
      write_reg(CSR_NEAR,     64'h8000_0000);
      write_reg(CSR_FAR,      64'h7FFF_FFFF);
      write_reg(CSR_NEAR_EXT, {64{1'b1}});
      write_reg(CSR_FAR_EXT,  {64{1'b1}});
      gen_full = 1;
      set_idling(8, 8);
      add_random(80);
      drain();

      // one zero half-extent: no selection while it stays
      write_reg(CSR_FAR_EXT, {32'h0000_0001, 32'h0000_0000});
      set_idling(30, 30);
      add_random(30);
      drain();

      // back to a plain frustum with mixed idling
      gen_full = 0;
      set_frustum(0, 0, 0, 1, 32'h0000_0000, 32'h0040_0000,
                  {32'h0000_0001, 32'h0000_0001}, {32'h0040_0000, 32'h0040_0000});
      gen_lo = 0; gen_hi = 16384; gen_lat = 9000;
      set_idling(71, 71);
      add_random(60);
      drain();

      if (selected_cells.size() != 0) err_count++;
      if (err_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
